@@ rtl/assert_macros.svh @@
// Assertion macros shared by the timer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("forbidden condition");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

@@ rtl/mcit_pkg.sv @@
// Package: types, codes and constants of the interval timer.
`default_nettype none
package mcit_pkg;
	localparam int CHANNELS_DEF    = 8;
	localparam int COUNT_WIDTH_DEF = 32;
	localparam int OP_W   = 3;
	localparam int CH_W   = 8;
	localparam int VAL_W  = 32;
	localparam int READ_W = 32;
	localparam int MASK_W = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [OP_W-1:0] {
		OP_TICK     = 3'd0,
		OP_START    = 3'd1,
		OP_STOP     = 3'd2,
		OP_RD_ELAP  = 3'd3,
		OP_RD_REM   = 3'd4,
		OP_INIT     = 3'd5,
		OP_DEINIT   = 3'd6
	} op_t;

	localparam logic [CFG_IDX_W-1:0] REG_CONTINUOUS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NOTIFY     = 1'd1;

	typedef struct packed {
		logic load;
		logic clear;
		logic tick;
		logic start;
		logic stop;
		logic rd_elap;
		logic rd_rem;
		logic ignore;
	} cmd_t;

	typedef struct packed {
		logic ch_valid;
	} status_t;
endpackage
`default_nettype wire

@@ rtl/mcit_in_if.sv @@
// Input channel interface: operation transactions.
`default_nettype none
interface mcit_in_if import mcit_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [CH_W-1:0]   channel;
	logic [VAL_W-1:0]  value;
	modport source (output valid, output opcode, output channel, output value, input ready);
	modport sink   (input valid, input opcode, input channel, input value, output ready);
endinterface
`default_nettype wire

@@ rtl/mcit_out_if.sv @@
// Output channel interface: result transactions.
`default_nettype none
interface mcit_out_if import mcit_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [READ_W-1:0] read_value;
	logic [MASK_W-1:0] fired_mask;
	logic              ignored;
	modport source (output valid, output read_value, output fired_mask, output ignored,
		input ready);
	modport sink   (input valid, input read_value, input fired_mask, input ignored,
		output ready);
endinterface
`default_nettype wire

@@ rtl/multi_channel_interval_timer.sv @@
// Top level: bank of interval timer channels with operation and result channels.
// Each operation transaction (tick, start, stop, read elapsed, read remaining, init,
// deinit) is decoded and executed in the cycle it is accepted, and its one result
// lands in an output register; the block takes one transaction per cycle while that
// register is empty or being drained, so ready drops only when a result waits and
// the sink stalls. A tick advances all running channels at once through one incrementer
// and comparator per channel. The mode and notify registers are written through the
// plain write port and take effect on the next tick. Before init, every operation
// other than init and deinit is flagged as ignored, as is any start, stop or read on
// a channel at or above CHANNELS.
`default_nettype none
module multi_channel_interval_timer import mcit_pkg::*; #(
	parameter int CHANNELS    = CHANNELS_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	mcit_in_if.sink                    in_ch,
	mcit_out_if.source                 out_ch,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);
	cmd_t    cmd;
	status_t status;

	mcit_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.opcode    (in_ch.opcode),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	mcit_dp #(
		.CHANNELS    (CHANNELS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.channel    (in_ch.channel),
		.value      (in_ch.value),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.read_value (out_ch.read_value),
		.fired_mask (out_ch.fired_mask),
		.ignored    (out_ch.ignored)
	);
endmodule
`default_nettype wire

@@ rtl/mcit_ctrl.sv @@
// Controller: handshake, enable state and operation decode.
`default_nettype none
`include "assert_macros.svh"
module mcit_ctrl import mcit_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [OP_W-1:0] opcode,
	output logic                 out_valid,
	input  wire logic            out_ready,
	input  wire status_t         status,
	output cmd_t                 cmd
);
	typedef enum logic {ST_EMPTY, ST_FULL} state_t;

	state_t state_q;
	logic   enabled_q;
	logic   accept;

	assign out_valid = (state_q == ST_FULL);
	assign in_ready  = (state_q == ST_EMPTY) || out_ready;
	assign accept    = in_valid && in_ready;

	always_comb begin
		cmd      = '0;
		cmd.load = accept;
		if (accept) begin
			unique case (opcode)
				OP_INIT, OP_DEINIT: cmd.clear = 1'b1;
				OP_TICK: begin
					cmd.tick   = enabled_q;
					cmd.ignore = !enabled_q;
				end
				OP_START, OP_STOP, OP_RD_ELAP, OP_RD_REM: begin
					if (!enabled_q || !status.ch_valid) begin
						cmd.ignore = 1'b1;
					end else begin
						cmd.start   = (opcode == OP_START);
						cmd.stop    = (opcode == OP_STOP);
						cmd.rd_elap = (opcode == OP_RD_ELAP);
						cmd.rd_rem  = (opcode == OP_RD_REM);
					end
				end
				default: cmd.ignore = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_EMPTY;
			enabled_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= ST_FULL;
			end else if (out_ready) begin
				state_q <= ST_EMPTY;
			end
			if (accept && opcode == OP_INIT) begin
				enabled_q <= 1'b1;
			end else if (accept && opcode == OP_DEINIT) begin
				enabled_q <= 1'b0;
			end
		end
	end

	`ASSERT_CLK(a_accept_fills, clk, arst_n, accept |=> out_valid)
	`ASSERT_CLK(a_deinit_disables, clk, arst_n, (accept && opcode == OP_DEINIT) |=> !enabled_q)
	`ASSERT_NEVER(a_cmd_exclusive, clk, arst_n,
		!$onehot0({cmd.clear, cmd.tick, cmd.start, cmd.stop, cmd.rd_elap, cmd.rd_rem, cmd.ignore}))
endmodule
`default_nettype wire

@@ rtl/mcit_dp.sv @@
// Datapath: channel counters, mode registers and result register.
`default_nettype none
`include "assert_macros.svh"
module mcit_dp import mcit_pkg::*; #(
	parameter int CHANNELS    = CHANNELS_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	output status_t                    status,
	input  wire logic [CH_W-1:0]       channel,
	input  wire logic [VAL_W-1:0]      value,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output logic [READ_W-1:0]          read_value,
	output logic [MASK_W-1:0]          fired_mask,
	output logic                       ignored
);
	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [COUNT_WIDTH-1:0] target_q  [CHANNELS];
	logic [COUNT_WIDTH-1:0] elapsed_q [CHANNELS];
	logic [COUNT_WIDTH-1:0] inc       [CHANNELS];
	logic [CHANNELS-1:0]    running_q;
	logic [CHANNELS-1:0]    expire;
	logic [CHANNELS-1:0]    cont_bit;
	logic [CHANNELS-1:0]    notify_bit;
	logic [MASK_W-1:0]      cont_q;
	logic [MASK_W-1:0]      notify_q;
	logic [MASK_W-1:0]      fired_d;
	logic [IDX_W-1:0]       idx;
	logic [COUNT_WIDTH-1:0] sel_el;
	logic [COUNT_WIDTH-1:0] sel_tg;
	logic [COUNT_WIDTH-1:0] remain;
	logic [READ_W-1:0]      read_d;
	logic [READ_W-1:0]      read_value_q;
	logic [MASK_W-1:0]      fired_q;
	logic                   ignored_q;

	assign status.ch_valid = int'(channel) < CHANNELS;
	assign idx = channel[IDX_W-1:0];

	for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
		assign inc[c]    = elapsed_q[c] + COUNT_WIDTH'(1);
		assign expire[c] = running_q[c] && (inc[c] >= target_q[c]);
		if (c < MASK_W) begin : g_mode
			assign cont_bit[c]   = cont_q[c];
			assign notify_bit[c] = notify_q[c];
		end else begin : g_nomode
			assign cont_bit[c]   = 1'b0;
			assign notify_bit[c] = 1'b0;
		end
	end

	for (genvar m = 0; m < MASK_W; m++) begin : g_fired
		if (m < CHANNELS) begin : g_on
			assign fired_d[m] = expire[m] && notify_bit[m];
		end else begin : g_off
			assign fired_d[m] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cont_q   <= '0;
			notify_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_CONTINUOUS: cont_q   <= cfg_wdata;
				REG_NOTIFY:     notify_q <= cfg_wdata;
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
		end else begin
			for (int c = 0; c < CHANNELS; c++) begin
				priority if (cmd.clear) begin
					running_q[c] <= 1'b0;
				end else if (cmd.start && idx == IDX_W'(c)) begin
					running_q[c] <= 1'b1;
				end else if (cmd.stop && idx == IDX_W'(c)) begin
					running_q[c] <= 1'b0;
				end else if (cmd.tick && expire[c] && !cont_bit[c]) begin
					running_q[c] <= 1'b0;
				end else begin
					running_q[c] <= running_q[c];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				target_q[c]  <= '0;
				elapsed_q[c] <= '0;
			end
		end else begin
			for (int c = 0; c < CHANNELS; c++) begin
				priority if (cmd.clear) begin
					target_q[c]  <= '0;
					elapsed_q[c] <= '0;
				end else if (cmd.start && idx == IDX_W'(c)) begin
					target_q[c]  <= COUNT_WIDTH'(value);
					elapsed_q[c] <= '0;
				end else if (cmd.tick && running_q[c]) begin
					elapsed_q[c] <= (expire[c] && cont_bit[c]) ? '0 : inc[c];
				end else begin
					elapsed_q[c] <= elapsed_q[c];
				end
			end
		end
	end

	assign sel_el = elapsed_q[idx];
	assign sel_tg = target_q[idx];
	assign remain = (running_q[idx] && sel_el < sel_tg) ? sel_tg - sel_el : '0;

	always_comb begin
		priority if (cmd.rd_elap) begin
			read_d = READ_W'(sel_el);
		end else if (cmd.rd_rem) begin
			read_d = READ_W'(remain);
		end else begin
			read_d = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			read_value_q <= read_d;
			fired_q      <= cmd.tick ? fired_d : '0;
			ignored_q    <= cmd.ignore;
		end
	end

	assign read_value = read_value_q;
	assign fired_mask = fired_q;
	assign ignored    = ignored_q;

	`ASSERT_CLK(a_clear_stops_all, clk, arst_n, cmd.clear |=> running_q == '0)
	`ASSERT_CLK(a_ignored_is_quiet, clk, arst_n,
		(cmd.load && cmd.ignore) |=> (fired_q == '0 && read_value_q == '0))
endmodule
`default_nettype wire

@@ tb/mcit_timer_checker.sv @@
// Checker: predicts interval timer results from observed operations and compares them.
module mcit_timer_checker import mcit_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	mcit_in_if                    op_mon,
	mcit_out_if                   result_mon,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    fail_count,
	output int                    pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_CH = CHANNELS_DEF;

	typedef struct packed {
		logic [READ_W-1:0] read_value;
		logic [MASK_W-1:0] fired_mask;
		logic              ignored;
	} timer_result_t;

	logic [COUNT_WIDTH_DEF-1:0] target_cnt [NUM_CH];
	logic [COUNT_WIDTH_DEF-1:0] elapsed_cnt [NUM_CH];
	logic [NUM_CH-1:0]          running;
	logic                       enabled;
	logic [MASK_W-1:0]          cont_mask;
	logic [MASK_W-1:0]          notify_mask;
	timer_result_t              timer_results_q [$];
	int                         mismatches;

	function automatic void clear_timers();
		for (int c = 0; c < NUM_CH; c++) begin
			target_cnt[c]  = '0;
			elapsed_cnt[c] = '0;
		end
		running = '0;
	endfunction

	function automatic timer_result_t execute_timer_op(logic [OP_W-1:0] op,
		logic [CH_W-1:0] ch, logic [VAL_W-1:0] val);
		timer_result_t res;
		int c;
		res = '0;
		case (op)
			OP_INIT, OP_DEINIT: begin
				clear_timers();
				enabled = (op == OP_INIT);
			end
			OP_TICK: begin
				if (!enabled) begin
					res.ignored = 1'b1;
				end else begin
					for (c = 0; c < NUM_CH; c++) begin
						if (running[c]) begin
							elapsed_cnt[c] = elapsed_cnt[c] + 1'b1;
							if (elapsed_cnt[c] >= target_cnt[c]) begin
								if (notify_mask[c])
									res.fired_mask[c] = 1'b1;
								if (cont_mask[c])
									elapsed_cnt[c] = '0;
								else
									running[c] = 1'b0;
							end
						end
					end
				end
			end
			OP_START, OP_STOP, OP_RD_ELAP, OP_RD_REM: begin
				if (!enabled || ch >= NUM_CH) begin
					res.ignored = 1'b1;
				end else begin
					c = ch;
					case (op)
						OP_START: begin
							target_cnt[c]  = val;
							elapsed_cnt[c] = '0;
							running[c]     = 1'b1;
						end
						OP_STOP:    running[c] = 1'b0;
						OP_RD_ELAP: res.read_value = elapsed_cnt[c];
						default: begin
							if (running[c] && elapsed_cnt[c] < target_cnt[c])
								res.read_value = target_cnt[c] - elapsed_cnt[c];
						end
					endcase
				end
			end
			default: res.ignored = 1'b1;
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		timer_result_t want;
		if (!arst_n) begin
			clear_timers();
			enabled     = 1'b0;
			cont_mask   = '0;
			notify_mask = '0;
			timer_results_q.delete();
			mismatches  = 0;
			fail_count    <= 0;
			pending_count <= 0;
		end else begin
			if (result_mon.valid && result_mon.ready) begin
				if (timer_results_q.size() == 0) begin
					$error("result transaction with no operation outstanding");
					mismatches++;
				end else begin
					want = timer_results_q.pop_front();
					if (result_mon.read_value !== want.read_value) begin
						$error("read_value: expected %0h, got %0h",
							want.read_value, result_mon.read_value);
						mismatches++;
					end
					if (result_mon.fired_mask !== want.fired_mask) begin
						$error("fired_mask: expected %0h, got %0h",
							want.fired_mask, result_mon.fired_mask);
						mismatches++;
					end
					if (result_mon.ignored !== want.ignored) begin
						$error("ignored: expected %0b, got %0b",
							want.ignored, result_mon.ignored);
						mismatches++;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_idx == REG_CONTINUOUS)
					cont_mask = cfg_wdata;
				else if (cfg_idx == REG_NOTIFY)
					notify_mask = cfg_wdata;
			end
			if (op_mon.valid && op_mon.ready)
				timer_results_q.push_back(execute_timer_op(op_mon.opcode, op_mon.channel,
					op_mon.value));
			fail_count    <= mismatches;
			pending_count <= timer_results_q.size();
		end
	end
endmodule

@@ tb/tb_multi_channel_interval_timer.sv @@
// Testbench top: clock, reset, operation and mode stimulus, and the final verdict.
module tb_multi_channel_interval_timer import mcit_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
	localparam int NUM_CH = CHANNELS_DEF;
	localparam int OPS_PER_PHASE = 100;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    fail_count;
	int                    pending_count;
	bit                    quiet;
	int                    stall_pct;
	int                    ops_sent;
	int                    modes_used;

	mcit_in_if  op_bus();
	mcit_out_if result_bus();

	multi_channel_interval_timer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (op_bus),
		.out_ch    (result_bus),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	mcit_timer_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.op_mon        (op_bus),
		.result_mon    (result_bus),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb_multi_channel_interval_timer: FAIL");
		$finish;
	end

	// result sink: random stall bursts, none once quiet
	initial begin : result_sink
		int hold;
		hold = 0;
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0 && !quiet) begin
				hold--;
				result_bus.ready <= 1'b0;
			end else if (!quiet && $urandom_range(1, 100) <= stall_pct) begin
				hold = $urandom_range(0, 6);
				result_bus.ready <= 1'b0;
			end else begin
				hold = 0;
				result_bus.ready <= 1'b1;
			end
		end
	end

	task automatic send_op(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
		input logic [VAL_W-1:0] val);
		if (!quiet && $urandom_range(1, 100) <= stall_pct) begin
			op_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		op_bus.valid   <= 1'b1;
		op_bus.opcode  <= op;
		op_bus.channel <= ch;
		op_bus.value   <= val;
		do @(posedge clk); while (!op_bus.ready);
		ops_sent++;
	endtask

	task automatic program_modes(input logic [CFG_DATA_W-1:0] cont,
		input logic [CFG_DATA_W-1:0] notify);
		cfg_we    <= 1'b1;
		cfg_idx   <= REG_CONTINUOUS;
		cfg_wdata <= cont;
		@(posedge clk);
		cfg_idx   <= REG_NOTIFY;
		cfg_wdata <= notify;
		@(posedge clk);
		cfg_we <= 1'b0;
		modes_used++;
	endtask

	task automatic drain();
		op_bus.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_random_op();
		int pick;
		int vpick;
		logic [CH_W-1:0]  ch;
		logic [VAL_W-1:0] val;
		pick  = $urandom_range(0, 99);
		vpick = $urandom_range(0, 99);
		if ($urandom_range(0, 9) == 0)
			ch = CH_W'($urandom_range(NUM_CH, 255));
		else
			ch = CH_W'($urandom_range(0, NUM_CH - 1));
		if (vpick < 75)
			val = VAL_W'($urandom_range(0, 12));
		else if (vpick < 90)
			val = $urandom;
		else
			val = $urandom_range(0, 1) ? '1 : '0;
		if (pick < 40)
			send_op(OP_TICK, ch, val);
		else if (pick < 60)
			send_op(OP_START, ch, val);
		else if (pick < 67)
			send_op(OP_STOP, ch, val);
		else if (pick < 77)
			send_op(OP_RD_ELAP, ch, val);
		else if (pick < 87)
			send_op(OP_RD_REM, ch, val);
		else if (pick < 92)
			send_op(OP_INIT, ch, val);
		else if (pick < 94)
			send_op(OP_DEINIT, ch, val);
		else
			send_op(OP_UNUSED, ch, val);
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] cont_set [4];
		logic [CFG_DATA_W-1:0] notify_set [4];
		int pct_set [4];
		op_bus.valid   <= 1'b0;
		op_bus.opcode  <= OP_TICK;
		op_bus.channel <= '0;
		op_bus.value   <= '0;
		cfg_we    <= 1'b0;
		cfg_idx   <= REG_CONTINUOUS;
		cfg_wdata <= '0;
		arst_n    <= 1'b0;
		quiet      = 1'b0;
		stall_pct  = 25;
		ops_sent   = 0;
		modes_used = 0;
		cont_set   = '{8'hFF, CFG_DATA_W'($urandom), 8'h00, CFG_DATA_W'($urandom)};
		notify_set = '{8'hFF, CFG_DATA_W'($urandom), 8'h00, CFG_DATA_W'($urandom)};
		pct_set    = '{30, 10, 50, 0};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		program_modes(8'h00, 8'hFF);
		// not yet initialized
		send_op(OP_TICK, 8'd0, 32'd0);
		send_op(OP_START, 8'd0, 32'd5);
		send_op(OP_RD_ELAP, 8'd0, 32'd0);
		send_op(OP_UNUSED, 8'd0, 32'd0);
		send_op(OP_DEINIT, 8'd0, 32'd0);
		send_op(OP_INIT, 8'd0, 32'd0);
		// zero target, short target, maximum target, out of range channels
		send_op(OP_START, 8'd0, 32'd0);
		send_op(OP_START, 8'd1, 32'd2);
		send_op(OP_START, 8'd7, 32'hFFFF_FFFF);
		send_op(OP_START, 8'd8, 32'd3);
		send_op(OP_STOP, 8'd255, 32'd0);
		send_op(OP_RD_REM, 8'd1, 32'd0);
		send_op(OP_TICK, 8'd0, 32'd0);
		send_op(OP_RD_ELAP, 8'd1, 32'd0);
		send_op(OP_RD_REM, 8'd0, 32'd0);
		send_op(OP_TICK, 8'd0, 32'd0);
		send_op(OP_RD_REM, 8'd7, 32'd0);
		send_op(OP_STOP, 8'd7, 32'd0);
		send_op(OP_RD_REM, 8'd7, 32'd0);
		send_op(OP_RD_ELAP, 8'd7, 32'd0);
		send_op(OP_UNUSED, 8'd255, 32'hFFFF_FFFF);
		send_op(OP_DEINIT, 8'd0, 32'd0);
		send_op(OP_RD_REM, 8'd1, 32'd0);
		send_op(OP_INIT, 8'd0, 32'd0);
		drain();

		for (int p = 0; p < 4; p++) begin
			program_modes(cont_set[p], notify_set[p]);
			stall_pct = pct_set[p];
			quiet     = (p == 3);
			repeat (OPS_PER_PHASE) send_random_op();
			drain();
		end

		$display("Ran %0d operation transactions under %0d mode settings,", ops_sent,
			modes_used);
		$display("covering one-shot and continuous expiry, stalls and ignored operations.");
		if (fail_count == 0 && pending_count == 0) begin
			$display("tb_multi_channel_interval_timer: PASS");
		end else begin
			$display("tb_multi_channel_interval_timer: FAIL");
		end
		$finish;
	end
endmodule

@@ files.f @@
+incdir+rtl
rtl/mcit_pkg.sv
rtl/mcit_in_if.sv
rtl/mcit_out_if.sv
rtl/mcit_ctrl.sv
rtl/mcit_dp.sv
rtl/multi_channel_interval_timer.sv
tb/mcit_timer_checker.sv
tb/tb_multi_channel_interval_timer.sv
